// ----- design/downlink_rbg_round_robin_allocator_core_macros.svh -----
// Assertion macros used by the checker file.
`ifndef DOWNLINK_RBG_ROUND_ROBIN_ALLOCATOR_CORE_MACROS_SVH
`define DOWNLINK_RBG_ROUND_ROBIN_ALLOCATOR_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define DRRA_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the condition.
`define DRRA_ASSERT_NXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// ----- design/drra_pkg.sv -----
`timescale 1ns / 1ps
package drra_pkg;
    localparam int KIND_W = 2;
    localparam logic [1:0] KIND_BSR  = 2'd0;
    localparam logic [1:0] KIND_CQI  = 2'd1;
    localparam logic [1:0] KIND_TRIG = 2'd2;
    localparam logic [1:0] CQI_P10   = 2'd0;
    localparam int MASK_W = 27;
    localparam logic [6:0] BW_MAX = 7'd110;

    // Queued command between the front and the back part
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] rnti;
        logic [7:0]  lcid;
        logic        act;
        logic [3:0]  cqi;
    } t_cmd;

    // One grant as it leaves the block
    typedef struct packed {
        logic [15:0] rnti;
        logic [7:0]  lcid;
        logic [26:0] mask;
        logic [6:0]  prb;
        logic [3:0]  cqi;
        logic        known;
        logic        last;
    } t_grant;

    function automatic logic [2:0] group_size(input logic [6:0] bw);
        if (bw < 7'd10) return 3'd1;
        if (bw < 7'd26) return 3'd2;
        if (bw < 7'd63) return 3'd3;
        return 3'd4;
    endfunction
endpackage

// ----- design/downlink_rbg_round_robin_allocator_core.sv -----
`timescale 1ns / 1ps
// Downlink resource-group round-robin allocator.
// Channels: s_axis carries reports and triggers (tuser = kind, tdata packs
// rnti, lcid, queue sizes, cqi type and cqi from bit 0 up); m_axis carries
// grants (tlast = last of the trigger). A cfg write channel sets the
// downlink bandwidth (reset 25 PRBs).
// A front stage filters items into a two-entry queue, so the input is taken
// while the back part works. In the back part a buffer report scans and
// compacts the flow table, and a CQI report scans the CQI table. A trigger
// counts active flows, runs two 5-step dividers, then per grant walks the
// CQI table and emits one item. These scans use the single read port of
// each memory, and the back part takes no new command until it is idle
// again. Reset empties both tables and the queue. When m_axis stalls the
// grant holds in its output register and the back part waits; the front
// queue keeps accepting until full.
module downlink_rbg_round_robin_allocator_core #(
    parameter int FLOW_ENTRIES = 32,
    parameter int CQI_ENTRIES  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // rnti[15:0], lcid[23:16], tx[55:24], retx[71:56], status[87:72],
    // cqi_type[89:88], wideband_cqi[93:90], zero fill
    input  logic [95:0] s_axis_tdata,
    // kind
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // rnti[15:0], lcid[23:16], mask[50:24], prb[57:51], cqi[61:58],
    // known[62], zero fill
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);
    import drra_pkg::*;

    logic [6:0] r_bw;
    logic q_v, q_r;
    t_cmd q_cmd;
    t_grant w_g;

    assign cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_bw <= 7'd25;
        else if (cfg_valid) r_bw <= cfg_data;
    end

    drra_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_kind(s_axis_tuser), .i_rnti(s_axis_tdata[15:0]),
        .i_lcid(s_axis_tdata[23:16]), .i_tx(s_axis_tdata[55:24]),
        .i_retx(s_axis_tdata[71:56]), .i_status(s_axis_tdata[87:72]),
        .i_cqi_type(s_axis_tdata[89:88]), .i_cqi(s_axis_tdata[93:90]),
        .o_valid(q_v), .i_ready(q_r), .o_cmd(q_cmd)
    );

    drra_back #(.FLOW_ENTRIES(FLOW_ENTRIES), .CQI_ENTRIES(CQI_ENTRIES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_v), .o_ready(q_r), .i_cmd(q_cmd), .i_bw(r_bw),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_grant(w_g)
    );

    assign m_axis_tdata = {1'b0, w_g.known, w_g.cqi, w_g.prb, w_g.mask,
                           w_g.lcid, w_g.rnti};
    assign m_axis_tlast = w_g.last;
endmodule

// ----- design/drra_front.sv -----
`timescale 1ns / 1ps
module drra_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [1:0]     i_kind,
    input  logic [15:0]    i_rnti,
    input  logic [7:0]     i_lcid,
    input  logic [31:0]    i_tx,
    input  logic [15:0]    i_retx,
    input  logic [15:0]    i_status,
    input  logic [1:0]     i_cqi_type,
    input  logic [3:0]     i_cqi,
    output logic           o_valid,
    input  logic           i_ready,
    output drra_pkg::t_cmd o_cmd
);
    import drra_pkg::*;

    // Two-entry command queue; useless items are dropped here
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_keep, w_push, w_pop;
    t_cmd       w_cmd;

    always_comb begin
        w_cmd.kind = i_kind;
        w_cmd.rnti = i_rnti;
        w_cmd.lcid = i_lcid;
        w_cmd.act  = (i_tx != 32'd0) || (i_retx != 16'd0) || (i_status != 16'd0);
        w_cmd.cqi  = i_cqi;
        w_keep = (i_kind == KIND_BSR) || (i_kind == KIND_TRIG)
              || ((i_kind == KIND_CQI) && (i_cqi_type == CQI_P10));
    end

    assign o_ready = (r_cnt != 2'd2);
    assign w_push  = i_valid && o_ready && w_keep;
    assign o_valid = (r_cnt != 2'd0);
    assign w_pop   = o_valid && i_ready;
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

// ----- design/drra_back.sv -----
`timescale 1ns / 1ps
module drra_back #(
    parameter int FLOW_ENTRIES = 32,
    parameter int CQI_ENTRIES  = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  drra_pkg::t_cmd   i_cmd,
    input  logic [6:0]       i_bw,
    output logic             o_valid,
    input  logic             i_ready,
    output drra_pkg::t_grant o_grant
);
    import drra_pkg::*;

    localparam int FW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int CW = (CQI_ENTRIES > 1) ? $clog2(CQI_ENTRIES) : 1;
    localparam int FC = $clog2(FLOW_ENTRIES + 1);
    localparam int CC = $clog2(CQI_ENTRIES + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_BSCAN = 10'b0000000010,
        S_BAPP  = 10'b0000000100,
        S_CSCAN = 10'b0000001000,
        S_COUNT = 10'b0000010000,
        S_DIV   = 10'b0000100000,
        S_FRD   = 10'b0001000000,
        S_CLOOK = 10'b0010000000,
        S_EMIT  = 10'b0100000000,
        S_WAIT  = 10'b1000000000
    } t_state;

    // Flow memory {rnti, lcid, active} and CQI memory {rnti, cqi}
    logic [24:0] r_fmem [FLOW_ENTRIES];
    logic [19:0] r_cmem [CQI_ENTRIES];
    logic [24:0] r_frd;
    logic [19:0] r_crd;
    logic        f_we, c_we;
    logic [FW-1:0] f_wa, f_ra;
    logic [CW-1:0] c_wa, c_ra;
    logic [24:0] f_wd;
    logic [19:0] c_wd;

    t_state r_st, n_st;
    t_cmd   r_cmd;
    logic [FC-1:0] r_fcnt, r_i, r_w;
    logic [CC-1:0] r_ccnt, r_k;
    logic          r_hit, r_rdv;
    logic [FC-1:0] r_nact;
    logic [2:0]    r_size;
    logic [4:0]    r_total, r_alloc, r_per, r_quo;
    logic [4:0]    r_prem;
    logic [6:0]    r_rem;
    logic [3:0]    r_dstep;
    logic [24:0]   r_flow;
    logic          r_known;
    logic [3:0]    r_cv;
    t_grant        r_out;
    logic          r_ov;

    logic [6:0] w_bw;
    assign w_bw = (i_bw > BW_MAX) ? BW_MAX : i_bw;

    always_ff @(posedge i_clk) begin
        if (f_we) r_fmem[f_wa] <= f_wd;
        r_frd <= r_fmem[f_ra];
    end
    always_ff @(posedge i_clk) begin
        if (c_we) r_cmem[c_wa] <= c_wd;
        r_crd <= r_cmem[c_ra];
    end

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = r_ov;
    assign o_grant = r_out;

    // Grant arithmetic for the current flow
    logic [4:0] w_left, w_g;
    logic [31:0] w_mask;
    logic [FC-1:0] w_in;
    assign w_left = r_total - r_alloc;
    assign w_g = (r_per > w_left) ? w_left : r_per;
    assign w_mask = ((32'd1 << w_g) - 32'd1) << r_alloc;
    assign w_in = r_i + 1'b1;

    // Divider step: steps 11..7 give total, 5..1 give the per-flow share
    logic [2:0]  w_sh;
    logic [6:0]  w_dsub;
    logic [10:0] w_nsub;
    assign w_sh = (r_dstep > 4'd6) ? 3'(r_dstep - 4'd7) : 3'(r_dstep - 4'd1);
    assign w_dsub = 7'(r_size) << w_sh;
    assign w_nsub = 11'(r_nact) << w_sh;

    // Address selection, writes and next state
    always_comb begin
        f_we = 1'b0; f_wa = r_w[FW-1:0]; f_wd = r_frd;
        c_we = 1'b0; c_wa = r_k[CW-1:0]; c_wd = {r_cmd.rnti, r_cmd.cqi};
        f_ra = r_i[FW-1:0];
        c_ra = r_k[CW-1:0];
        n_st = r_st;
        unique case (r_st)
            S_IDLE: begin
                f_ra = '0; c_ra = '0;
                if (i_valid) begin
                    unique case (i_cmd.kind)
                        KIND_BSR:  n_st = S_BSCAN;
                        KIND_CQI:  n_st = S_CSCAN;
                        KIND_TRIG: n_st = S_COUNT;
                        default:   n_st = S_IDLE;
                    endcase
                end
            end
            S_BSCAN: begin
                // compaction: keep entries not matching, read-ahead next
                f_ra = w_in[FW-1:0];
                if (r_i >= r_fcnt) n_st = S_BAPP;
                else if (r_rdv && !(r_frd[24:9] == r_cmd.rnti
                                    && r_frd[8:1] == r_cmd.lcid)) begin
                    f_we = 1'b1;
                end
            end
            S_BAPP: begin
                f_wd = {r_cmd.rnti, r_cmd.lcid, r_cmd.act};
                f_we = (r_w < FC'(FLOW_ENTRIES));
                n_st = S_IDLE;
            end
            S_CSCAN: begin
                c_ra = r_k[CW-1:0] + 1'b1;
                c_wa = r_k[CW-1:0];
                if (r_rdv && r_k < r_ccnt && r_crd[19:4] == r_cmd.rnti) begin
                    c_we = 1'b1; n_st = S_IDLE;
                end else if (r_k >= r_ccnt) begin
                    c_we = (r_ccnt < CC'(CQI_ENTRIES));
                    n_st = S_IDLE;
                end
            end
            S_COUNT: begin
                f_ra = w_in[FW-1:0];
                if (r_i >= r_fcnt) n_st = S_DIV;
            end
            S_DIV: begin
                f_ra = '0;
                if (r_dstep == 4'd0) begin
                    if (r_nact == '0 || r_total == 5'd0) n_st = S_IDLE;
                    else n_st = S_FRD;
                end
            end
            S_FRD: begin
                c_ra = '0;
                n_st = S_CLOOK;
            end
            S_CLOOK: begin
                c_ra = r_k[CW-1:0] + 1'b1;
                if ((r_rdv && r_k < r_ccnt && r_crd[19:4] == r_flow[24:9])
                    || r_k >= r_ccnt) n_st = S_EMIT;
            end
            S_EMIT: n_st = S_WAIT;
            S_WAIT: begin
                f_ra = r_i[FW-1:0];
                if (!r_ov) n_st = r_out.last ? S_IDLE : S_FRD;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_fcnt <= '0;
            r_ccnt <= '0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_ov && i_ready) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    r_cmd <= i_cmd; r_i <= '0; r_w <= '0; r_k <= '0;
                    r_rdv <= 1'b1; r_nact <= '0; r_alloc <= '0;
                    r_size <= group_size(w_bw);
                    r_rem <= w_bw;
                    r_quo <= '0;
                    r_dstep <= 4'd11;
                end
                S_BSCAN: begin
                    if (r_i < r_fcnt) begin
                        r_i <= w_in;
                        if (f_we) r_w <= r_w + 1'b1;
                    end
                end
                S_BAPP: begin
                    r_fcnt <= (r_w < FC'(FLOW_ENTRIES)) ? r_w + 1'b1 : r_w;
                end
                S_CSCAN: begin
                    r_k <= r_k + 1'b1;
                    if (n_st == S_IDLE && !(r_rdv && r_k < r_ccnt
                            && r_crd[19:4] == r_cmd.rnti) && c_we)
                        r_ccnt <= r_ccnt + 1'b1;
                end
                S_COUNT: begin
                    if (r_i < r_fcnt) begin
                        r_i <= w_in;
                        if (r_frd[0]) r_nact <= r_nact + 1'b1;
                    end
                end
                S_DIV: begin
                    // restoring dividers, one quotient bit a step
                    if (r_dstep != 4'd0) r_dstep <= r_dstep - 4'd1;
                    if (r_dstep > 4'd6) begin
                        // total = bw / size
                        if (r_rem >= w_dsub) begin
                            r_rem <= r_rem - w_dsub;
                            r_quo[w_sh] <= 1'b1;
                        end
                    end else if (r_dstep == 4'd6) begin
                        r_total <= r_quo;
                        r_prem <= r_quo;
                        r_per <= '0;
                    end else if (r_dstep != 4'd0) begin
                        // per = total / nact
                        if ({6'd0, r_prem} >= w_nsub) begin
                            r_prem <= r_prem - w_nsub[4:0];
                            r_per[w_sh] <= 1'b1;
                        end
                    end else if (r_per == 5'd0) begin
                        // at least one group per flow
                        r_per <= 5'd1;
                    end
                    r_i <= '0;
                end
                S_FRD: begin
                    r_flow <= r_frd; r_k <= '0; r_known <= 1'b0;
                end
                S_CLOOK: begin
                    r_k <= r_k + 1'b1;
                    if (r_rdv && r_k < r_ccnt && r_crd[19:4] == r_flow[24:9]) begin
                        r_known <= 1'b1; r_cv <= r_crd[3:0];
                    end else begin
                        r_cv <= 4'd0;
                    end
                end
                S_EMIT: begin
                    r_out.rnti  <= r_flow[24:9];
                    r_out.lcid  <= r_flow[8:1];
                    r_out.mask  <= w_mask[MASK_W-1:0];
                    r_out.prb   <= 7'(r_size * w_g);
                    r_out.cqi   <= r_known ? r_cv : 4'd0;
                    r_out.known <= r_known;
                    r_out.last  <= ((r_alloc + w_g) >= r_total) || (w_in >= r_fcnt);
                    r_ov <= 1'b1;
                    r_alloc <= r_alloc + w_g;
                    r_i <= w_in;
                end
                default: ;
            endcase
        end
    end
endmodule

// ----- design/drra_checker.sv -----
`timescale 1ns / 1ps
`include "downlink_rbg_round_robin_allocator_core_macros.svh"
module drra_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    `DRRA_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "grant dropped while stalled")
    `DRRA_ASSERT_IMP(a_mask, i_clk, i_rst_n, m_axis_tvalid, (m_axis_tdata[50:24] == 27'd0) == (m_axis_tdata[57:51] == 7'd0), "mask and prb disagree")
    `DRRA_ASSERT_IMP(a_cqi, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[62], m_axis_tdata[61:58] == 4'd0, "cqi set without known")
endmodule

bind downlink_rbg_round_robin_allocator_core drra_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
);
